[rtl/core/nnsa_pkg.sv]
// ----------------------------------------------------------------------------
// nnsa_pkg
// Shared widths, register indexes, beat structs and helpers for the
// nearest-neighbour scale addresser.
// ----------------------------------------------------------------------------
package nnsa_pkg;

   // Field widths
   localparam int POS_W      = 12;   // destination column / row
   localparam int DIM_W      = 13;   // strides and region sizes
   localparam int BASE_W     = 24;   // base pixel offsets
   localparam int IDX_W      = 27;   // byte indices
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   // Derived widths
   localparam int NUM_W   = POS_W * 2;       // col * region size, below MAX_DIM * 2^POS_W
   localparam int MUL_W   = POS_W + DIM_W;   // position times a 13-bit value
   localparam int PIX_W   = MUL_W + 1;       // base + product + position
   localparam int DIV_STEPS = POS_W;         // one quotient bit per cell

   // Largest region size honoured
   localparam int MAX_DIM = 4096;
   localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

   // Register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_SRC_STRIDE   = 3'd0,
      REG_SRC_BASE     = 3'd1,
      REG_SRC_REGION_W = 3'd2,
      REG_SRC_REGION_H = 3'd3,
      REG_DST_STRIDE   = 3'd4,
      REG_DST_BASE     = 3'd5,
      REG_DST_REGION_W = 3'd6,
      REG_DST_REGION_H = 3'd7
   } reg_index_type;

   // Register reset values
   localparam logic [DIM_W-1:0]  RST_STRIDE   = DIM_W'(640);
   localparam logic [BASE_W-1:0] RST_BASE     = '0;
   localparam logic [DIM_W-1:0]  RST_REGION_W = DIM_W'(640);
   localparam logic [DIM_W-1:0]  RST_REGION_H = DIM_W'(480);

   // Configuration as seen by the datapath, region sizes already clamped
   typedef struct packed {
      logic [DIM_W-1:0]  src_stride;
      logic [BASE_W-1:0] src_base;
      logic [DIM_W-1:0]  src_w;
      logic [DIM_W-1:0]  src_h;
      logic [DIM_W-1:0]  dst_stride;
      logic [BASE_W-1:0] dst_base;
      logic [DIM_W-1:0]  dst_w;
      logic [DIM_W-1:0]  dst_h;
   } cfg_type;

   // One division lane: partial remainder and numerator / quotient shifter
   typedef struct packed {
      logic [POS_W-1:0] rem;
      logic [POS_W-1:0] nq;
   } div_lane_type;

   // Payload handed from cell to cell
   typedef struct packed {
      logic             outside;
      div_lane_type     col;
      div_lane_type     row;
      logic [IDX_W-1:0] dst_byte;
   } cell_data_type;

   // Result beat
   typedef struct packed {
      logic [IDX_W-1:0] src_byte_index;
      logic [IDX_W-1:0] dst_byte_index;
      logic             outside_region;
   } rsp_type;

   // Limit a region size to MAX_DIM
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      return (v > DIM_MAX) ? DIM_MAX : v;
   endfunction

endpackage

[rtl/core/nearest_neighbor_scale_addresser.sv]
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_addresser
// Maps a destination position to the byte index of the nearest-neighbour
// RGB source pixel and of the BGRA destination pixel.
// ----------------------------------------------------------------------------
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    dst_col, dst_row
//   rsp      out        rsp_valid/rsp_ready    src/dst byte index, outside flag
//   csr      in         csr_valid/csr_ready    register index, write data
//
// One position is taken every cycle while no result beat waits in the skid
// entry; an accepted beat passes the input register, multiplier register,
// twelve division cells (one quotient bit each) and a source multiply stage,
// then the result register. Reset is synchronous and empties the pipeline. A
// stalled result parks one beat in a skid entry; the whole pipeline then holds.
// ----------------------------------------------------------------------------
module nearest_neighbor_scale_addresser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [nnsa_pkg::POS_W-1:0]      req_dst_col,
   input  logic [nnsa_pkg::POS_W-1:0]      req_dst_row,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [nnsa_pkg::IDX_W-1:0]      rsp_src_byte_index,
   output logic [nnsa_pkg::IDX_W-1:0]      rsp_dst_byte_index,
   output logic                            rsp_outside_region,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [nnsa_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [nnsa_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int STEPS = nnsa_pkg::DIV_STEPS;

   nnsa_pkg::cfg_type cfg;
   logic              advance;

   // Stage 0: input register
   logic                         s0_valid_ff;
   logic                         s0_outside_ff;
   logic [nnsa_pkg::POS_W-1:0]   s0_col_ff, s0_row_ff;
   logic                         s0_outside_in;

   // Stage 1: products
   logic                         s1_valid_ff;
   logic                         s1_outside_ff;
   logic [nnsa_pkg::POS_W-1:0]   s1_col_ff;
   logic [nnsa_pkg::NUM_W-1:0]   s1_ncol_ff, s1_nrow_ff;
   logic [nnsa_pkg::MUL_W-1:0]   s1_drow_ff;
   logic [nnsa_pkg::MUL_W-1:0]   mul_col, mul_row, mul_drow;

   // Division chain
   logic [STEPS:0]               cell_valid;
   nnsa_pkg::cell_data_type      cell_data [STEPS+1];
   logic [nnsa_pkg::PIX_W-1:0]   dst_pix;

   // Final stage: source row offset
   logic                         f1_valid_ff;
   logic                         f1_outside_ff;
   logic [nnsa_pkg::MUL_W-1:0]   f1_smul_ff;
   logic [nnsa_pkg::POS_W-1:0]   f1_scol_ff;
   logic [nnsa_pkg::IDX_W-1:0]   f1_dst_ff;
   logic [nnsa_pkg::MUL_W-1:0]   mul_src;
   logic [nnsa_pkg::PIX_W-1:0]   src_pix;
   nnsa_pkg::rsp_type            push_data;
   nnsa_pkg::rsp_type            rsp_data;

   nnsa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign req_ready = advance;

   // Flag positions beyond the destination region
   assign s0_outside_in = ({1'b0, req_dst_col} >= cfg.dst_w) ||
                          ({1'b0, req_dst_row} >= cfg.dst_h);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         f1_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
         s1_valid_ff <= s0_valid_ff;
         f1_valid_ff <= cell_valid[STEPS];
      end
   end

   // Capture the input beat
   always_ff @(posedge clock) begin
      if (advance) begin
         s0_col_ff     <= req_dst_col;
         s0_row_ff     <= req_dst_row;
         s0_outside_ff <= s0_outside_in;
      end
   end

   // Scale numerators and destination row offset
   assign mul_col  = {{nnsa_pkg::DIM_W{1'b0}}, s0_col_ff} *
                     {{nnsa_pkg::POS_W{1'b0}}, cfg.src_w};
   assign mul_row  = {{nnsa_pkg::DIM_W{1'b0}}, s0_row_ff} *
                     {{nnsa_pkg::POS_W{1'b0}}, cfg.src_h};
   assign mul_drow = {{nnsa_pkg::DIM_W{1'b0}}, s0_row_ff} *
                     {{nnsa_pkg::POS_W{1'b0}}, cfg.dst_stride};

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_outside_ff <= s0_outside_ff;
         s1_col_ff     <= s0_col_ff;
         s1_ncol_ff    <= mul_col[nnsa_pkg::NUM_W-1:0];
         s1_nrow_ff    <= mul_row[nnsa_pkg::NUM_W-1:0];
         s1_drow_ff    <= mul_drow;
      end
   end

   // Load the chain: upper numerator half is the first remainder, since the
   // quotient is known to fit POS_W bits inside the region
   assign dst_pix = {2'b00, cfg.dst_base} + {1'b0, s1_drow_ff} +
                    {{(nnsa_pkg::PIX_W-nnsa_pkg::POS_W){1'b0}}, s1_col_ff};

   assign cell_valid[0] = s1_valid_ff;
   always_comb begin
      cell_data[0].outside  = s1_outside_ff;
      cell_data[0].col.rem  = s1_ncol_ff[nnsa_pkg::NUM_W-1:nnsa_pkg::POS_W];
      cell_data[0].col.nq   = s1_ncol_ff[nnsa_pkg::POS_W-1:0];
      cell_data[0].row.rem  = s1_nrow_ff[nnsa_pkg::NUM_W-1:nnsa_pkg::POS_W];
      cell_data[0].row.nq   = s1_nrow_ff[nnsa_pkg::POS_W-1:0];
      cell_data[0].dst_byte = {dst_pix[nnsa_pkg::IDX_W-3:0], 2'b00};
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_cell
      nnsa_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (cell_valid[k]),
         .in_data   (cell_data[k]),
         .div_col   (cfg.dst_w),
         .div_row   (cfg.dst_h),
         .out_valid (cell_valid[k+1]),
         .out_data  (cell_data[k+1])
      );
   end

   // Source row offset from the row quotient
   assign mul_src = {{nnsa_pkg::DIM_W{1'b0}}, cell_data[STEPS].row.nq} *
                    {{nnsa_pkg::POS_W{1'b0}}, cfg.src_stride};

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_outside_ff <= cell_data[STEPS].outside;
         f1_smul_ff    <= mul_src;
         f1_scol_ff    <= cell_data[STEPS].col.nq;
         f1_dst_ff     <= cell_data[STEPS].dst_byte;
      end
   end

   // Source pixel times three, both indices dropped outside the region
   assign src_pix = {2'b00, cfg.src_base} + {1'b0, f1_smul_ff} +
                    {{(nnsa_pkg::PIX_W-nnsa_pkg::POS_W){1'b0}}, f1_scol_ff};

   always_comb begin
      push_data.outside_region = f1_outside_ff;
      if (f1_outside_ff) begin
         push_data.src_byte_index = '0;
         push_data.dst_byte_index = '0;
      end else begin
         push_data.src_byte_index = {src_pix, 1'b0} + {1'b0, src_pix};
         push_data.dst_byte_index = f1_dst_ff;
      end
   end

   nnsa_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f1_valid_ff && advance),
      .push_data  (push_data),
      .pipe_ready (advance),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_src_byte_index = rsp_data.src_byte_index;
   assign rsp_dst_byte_index = rsp_data.dst_byte_index;
   assign rsp_outside_region = rsp_data.outside_region;

endmodule

[rtl/core/nnsa_csr.sv]
// ----------------------------------------------------------------------------
// nnsa_csr
// Configuration registers with write port; presents clamped region sizes.
// ----------------------------------------------------------------------------
module nnsa_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [nnsa_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [nnsa_pkg::CSR_DATA_W-1:0] csr_data,
   output nnsa_pkg::cfg_type               cfg
);

   logic [nnsa_pkg::DIM_W-1:0]  src_stride_ff, src_w_ff, src_h_ff;
   logic [nnsa_pkg::DIM_W-1:0]  dst_stride_ff, dst_w_ff, dst_h_ff;
   logic [nnsa_pkg::BASE_W-1:0] src_base_ff, dst_base_ff;
   logic [nnsa_pkg::DIM_W-1:0]  wr_dim;
   logic [nnsa_pkg::BASE_W-1:0] wr_base;

   // Always able to take a write beat
   assign csr_ready = 1'b1;

   assign wr_dim  = csr_data[nnsa_pkg::DIM_W-1:0];
   assign wr_base = csr_data[nnsa_pkg::BASE_W-1:0];

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         src_stride_ff <= nnsa_pkg::RST_STRIDE;
         src_base_ff   <= nnsa_pkg::RST_BASE;
         src_w_ff      <= nnsa_pkg::RST_REGION_W;
         src_h_ff      <= nnsa_pkg::RST_REGION_H;
         dst_stride_ff <= nnsa_pkg::RST_STRIDE;
         dst_base_ff   <= nnsa_pkg::RST_BASE;
         dst_w_ff      <= nnsa_pkg::RST_REGION_W;
         dst_h_ff      <= nnsa_pkg::RST_REGION_H;
      end else if (csr_valid && csr_ready) begin
         case (nnsa_pkg::reg_index_type'(csr_index))
            nnsa_pkg::REG_SRC_STRIDE:   src_stride_ff <= wr_dim;
            nnsa_pkg::REG_SRC_BASE:     src_base_ff   <= wr_base;
            nnsa_pkg::REG_SRC_REGION_W: src_w_ff      <= wr_dim;
            nnsa_pkg::REG_SRC_REGION_H: src_h_ff      <= wr_dim;
            nnsa_pkg::REG_DST_STRIDE:   dst_stride_ff <= wr_dim;
            nnsa_pkg::REG_DST_BASE:     dst_base_ff   <= wr_base;
            nnsa_pkg::REG_DST_REGION_W: dst_w_ff      <= wr_dim;
            nnsa_pkg::REG_DST_REGION_H: dst_h_ff      <= wr_dim;
            default: ;
         endcase
      end
   end

   // Present configuration, region sizes limited to MAX_DIM
   always_comb begin
      cfg.src_stride = src_stride_ff;
      cfg.src_base   = src_base_ff;
      cfg.src_w      = nnsa_pkg::clamp_dim(src_w_ff);
      cfg.src_h      = nnsa_pkg::clamp_dim(src_h_ff);
      cfg.dst_stride = dst_stride_ff;
      cfg.dst_base   = dst_base_ff;
      cfg.dst_w      = nnsa_pkg::clamp_dim(dst_w_ff);
      cfg.dst_h      = nnsa_pkg::clamp_dim(dst_h_ff);
   end

endmodule

[rtl/core/nnsa_div_cell.sv]
// ----------------------------------------------------------------------------
// nnsa_div_cell
// One shift-subtract step for the column and row divisions; produces one
// quotient bit per lane and hands the beat to the next cell.
// ----------------------------------------------------------------------------
module nnsa_div_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  nnsa_pkg::cell_data_type       in_data,
   input  logic [nnsa_pkg::DIM_W-1:0]    div_col,
   input  logic [nnsa_pkg::DIM_W-1:0]    div_row,
   output logic                          out_valid,
   output nnsa_pkg::cell_data_type       out_data
);

   logic                    valid_ff;
   nnsa_pkg::cell_data_type data_ff;
   nnsa_pkg::cell_data_type data_in;

   // Shift the next numerator bit into the remainder, subtract if it fits.
   // The remainder stays below the divisor, so it fits POS_W bits.
   function automatic nnsa_pkg::div_lane_type div_step(
      input nnsa_pkg::div_lane_type     lane,
      input logic [nnsa_pkg::DIM_W-1:0] d
   );
      logic [nnsa_pkg::DIM_W-1:0] trial;
      logic [nnsa_pkg::DIM_W-1:0] diff;
      logic                       fits;
      nnsa_pkg::div_lane_type     res;
      trial    = {lane.rem, lane.nq[nnsa_pkg::POS_W-1]};
      fits     = (trial >= d);
      diff     = trial - d;
      res.rem  = fits ? diff[nnsa_pkg::POS_W-1:0] : trial[nnsa_pkg::POS_W-1:0];
      res.nq   = {lane.nq[nnsa_pkg::POS_W-2:0], fits};
      return res;
   endfunction

   always_comb begin
      data_in     = in_data;
      data_in.col = div_step(in_data.col, div_col);
      data_in.row = div_step(in_data.row, div_row);
   end

   // Advance with the rest of the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/core/nnsa_out_buf.sv]
// ----------------------------------------------------------------------------
// nnsa_out_buf
// Result register with one skid entry; parts the pipeline from the
// result channel.
// ----------------------------------------------------------------------------
module nnsa_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  nnsa_pkg::rsp_type push_data,
   output logic              pipe_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output nnsa_pkg::rsp_type rsp_data
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   nnsa_pkg::rsp_type main_data_ff, main_data_in;
   nnsa_pkg::rsp_type skid_data_ff, skid_data_in;

   // Pipeline may move while the skid entry is free
   assign pipe_ready = !skid_valid_ff;

   // Refill the result register from skid first, else from the pipeline;
   // park a beat in skid while the result is stalled
   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!main_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push_valid;
            main_data_in  = push_data;
         end
      end else if (push_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_data_ff;

endmodule

[rtl/core/nnsa_checker.sv]
// ----------------------------------------------------------------------------
// nnsa_checker
// Port-level checks on the scale addresser, bound to the top level.
// ----------------------------------------------------------------------------
module nnsa_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [nnsa_pkg::IDX_W-1:0] rsp_src_byte_index,
   input logic [nnsa_pkg::IDX_W-1:0] rsp_dst_byte_index,
   input logic                       rsp_outside_region
);

   // A stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_src_byte_index) &&
      $stable(rsp_dst_byte_index) && $stable(rsp_outside_region))
      else $error("result beat changed while stalled");

   // Outside beats carry zero indices
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outside_region |->
      rsp_src_byte_index == '0 && rsp_dst_byte_index == '0)
      else $error("outside beat with non-zero index");

   // Destination index is a whole BGRA pixel
   a_dst_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dst_byte_index[1:0] == 2'b00)
      else $error("destination index not pixel aligned");

   // Reset empties the result side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // The input only stalls behind a waiting result beat
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid)
      else $error("request stalled with no result waiting");

endmodule

bind nearest_neighbor_scale_addresser nnsa_checker u_nnsa_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_src_byte_index (rsp_src_byte_index),
   .rsp_dst_byte_index (rsp_dst_byte_index),
   .rsp_outside_region (rsp_outside_region)
);

[test/tb_nearest_neighbor_scale_addresser.sv]
// ----------------------------------------------------------------------------
// tb_nearest_neighbor_scale_addresser
// Self-checking bench for the nearest-neighbour scale addresser. Positions go
// in on the request channel. Each accepted beat is predicted from a local copy
// of the register file and queued. Result beats are then compared in order.
// Register settings change between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_nearest_neighbor_scale_addresser;
   timeunit 1ns;
   timeprecision 1ps;

   import nnsa_pkg::*;

   localparam int PIPE_LATENCY = 15;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int NUM_REGS     = 8;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [POS_W-1:0]      req_dst_col;
   logic [POS_W-1:0]      req_dst_row;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [IDX_W-1:0]      rsp_src_byte_index;
   logic [IDX_W-1:0]      rsp_dst_byte_index;
   logic                  rsp_outside_region;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Local copy of the register file
   logic [DIM_W-1:0]  cfg_src_stride;
   logic [BASE_W-1:0] cfg_src_base;
   logic [DIM_W-1:0]  cfg_src_w;
   logic [DIM_W-1:0]  cfg_src_h;
   logic [DIM_W-1:0]  cfg_dst_stride;
   logic [BASE_W-1:0] cfg_dst_base;
   logic [DIM_W-1:0]  cfg_dst_w;
   logic [DIM_W-1:0]  cfg_dst_h;

   // Register writes waiting for the next idle point
   logic [CSR_DATA_W-1:0] staged_value [NUM_REGS];
   logic [NUM_REGS-1:0]   staged_mask;

   rsp_type expected_addresses [$];
   int      mismatch_count;
   int      cycle_count;
   bit      idle_enabled;
   int      rsp_hold_cycles;

   nearest_neighbor_scale_addresser dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_dst_col        (req_dst_col),
      .req_dst_row        (req_dst_row),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_src_byte_index (rsp_src_byte_index),
      .rsp_dst_byte_index (rsp_dst_byte_index),
      .rsp_outside_region (rsp_outside_region),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Give up on a hung run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // Region sizes above the largest honoured size are taken as that size
   function automatic longint unsigned bounded_dim(input logic [DIM_W-1:0] v);
      return (v > MAX_DIM) ? longint'(MAX_DIM) : longint'(v);
   endfunction

   // Work out the byte indices for one destination position
   function automatic rsp_type predict_addresses(input logic [POS_W-1:0] col,
                                                 input logic [POS_W-1:0] row);
      rsp_type          r;
      longint unsigned  dw, dh, sw, sh, scol, srow, spix, dpix;
      r  = '0;
      dw = bounded_dim(cfg_dst_w);
      dh = bounded_dim(cfg_dst_h);
      sw = bounded_dim(cfg_src_w);
      sh = bounded_dim(cfg_src_h);
      if (col >= dw || row >= dh) begin
         r.outside_region = 1'b1;
         return r;
      end
      scol = (col * sw) / dw;
      srow = (row * sh) / dh;
      spix = cfg_src_base + srow * cfg_src_stride + scol;
      dpix = cfg_dst_base + row * cfg_dst_stride + col;
      r.src_byte_index = IDX_W'(spix * 3);
      r.dst_byte_index = IDX_W'(dpix * 4);
      return r;
   endfunction

   function automatic void store_setting(input reg_index_type idx,
                                         input logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_SRC_STRIDE:   cfg_src_stride = value[DIM_W-1:0];
         REG_SRC_BASE:     cfg_src_base   = value[BASE_W-1:0];
         REG_SRC_REGION_W: cfg_src_w      = value[DIM_W-1:0];
         REG_SRC_REGION_H: cfg_src_h      = value[DIM_W-1:0];
         REG_DST_STRIDE:   cfg_dst_stride = value[DIM_W-1:0];
         REG_DST_BASE:     cfg_dst_base   = value[BASE_W-1:0];
         REG_DST_REGION_W: cfg_dst_w      = value[DIM_W-1:0];
         REG_DST_REGION_H: cfg_dst_h      = value[DIM_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void stage_register(input reg_index_type idx,
                                          input logic [CSR_DATA_W-1:0] value);
      staged_value[int'(idx)] = value;
      staged_mask[int'(idx)]  = 1'b1;
   endfunction

   // Mostly legal sizes, with zero, one, the limit and oversized values mixed in
   function automatic logic [CSR_DATA_W-1:0] pick_dim_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CSR_DATA_W'(1);
         2:       return CSR_DATA_W'(MAX_DIM);
         3:       return CSR_DATA_W'($urandom_range(MAX_DIM + 1, 8191));
         4:       return CSR_DATA_W'($urandom);
         default: return CSR_DATA_W'($urandom_range(1, MAX_DIM));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_base_value();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   // Mostly positions inside the region, with corners, edges and noise
   function automatic void pick_position(output logic [POS_W-1:0] col,
                                         output logic [POS_W-1:0] row);
      longint unsigned dw, dh;
      int unsigned     choice;
      dw     = bounded_dim(cfg_dst_w);
      dh     = bounded_dim(cfg_dst_h);
      choice = $urandom_range(0, 9);
      if (dw == 0 || dh == 0 || choice == 0) begin
         col = POS_W'($urandom);
         row = POS_W'($urandom);
      end else if (choice == 1) begin
         col = POS_W'(dw - 1);
         row = POS_W'(dh - 1);
      end else if (choice == 2) begin
         col = POS_W'(dw);
         row = POS_W'($urandom_range(0, int'(dh - 1)));
      end else if (choice == 3) begin
         col = POS_W'($urandom_range(0, int'(dw - 1)));
         row = POS_W'(dh);
      end else begin
         col = POS_W'($urandom_range(0, int'(dw - 1)));
         row = POS_W'($urandom_range(0, int'(dh - 1)));
      end
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned want,
                                  input longint unsigned got);
      if (mismatch_count < 50)
         $display("mismatch on %s: expected %0d, got %0d", what, want, got);
      mismatch_count++;
   endtask

   // Offer one position and queue its prediction once the beat is taken
   task automatic send_position(input logic [POS_W-1:0] col,
                                input logic [POS_W-1:0] row);
      int gap;
      gap = idle_enabled ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         if (req_valid) req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_dst_col <= col;
      req_dst_row <= row;
      do @(posedge clock); while (!req_ready);
      expected_addresses.push_back(predict_addresses(col, row));
   endtask

   // Drop the request and hold until every queued result has come back
   task automatic wait_drained();
      if (req_valid) req_valid <= 1'b0;
      while (expected_addresses.size() != 0) @(posedge clock);
   endtask

   // Write every staged register, back to back, with the pipeline empty
   task automatic commit_registers();
      int i;
      wait_drained();
      for (i = 0; i < NUM_REGS; i++) begin
         if (staged_mask[i]) begin
            csr_valid <= 1'b1;
            csr_index <= reg_index_type'(i);
            csr_data  <= staged_value[i];
            do @(posedge clock); while (!csr_ready);
            store_setting(reg_index_type'(i), staged_value[i]);
         end
      end
      if (csr_valid) csr_valid <= 1'b0;
      staged_mask = '0;
   endtask

   task automatic test_reset_defaults();
      idle_enabled = 1'b1;
      send_position(12'd0, 12'd0);
      send_position(12'd639, 12'd479);
      send_position(12'd640, 12'd0);
      send_position(12'd0, 12'd480);
      send_position(12'd4095, 12'd4095);
      send_position(12'd320, 12'd240);
      wait_drained();
   endtask

   task automatic test_zero_regions();
      // Zero destination width: everything lies outside
      stage_register(REG_DST_REGION_W, '0);
      commit_registers();
      send_position(12'd0, 12'd0);
      send_position(12'd5, 12'd5);
      // Zero destination height
      stage_register(REG_DST_REGION_W, CSR_DATA_W'(100));
      stage_register(REG_DST_REGION_H, '0);
      commit_registers();
      send_position(12'd0, 12'd0);
      // Zero source size selects source column and row zero
      stage_register(REG_DST_REGION_H, CSR_DATA_W'(50));
      stage_register(REG_SRC_REGION_W, '0);
      stage_register(REG_SRC_REGION_H, '0);
      stage_register(REG_SRC_BASE, CSR_DATA_W'(1234));
      stage_register(REG_SRC_STRIDE, CSR_DATA_W'(77));
      commit_registers();
      send_position(12'd99, 12'd49);
      send_position(12'd0, 12'd0);
      wait_drained();
   endtask

   task automatic test_oversized_regions();
      // Oversized sizes clamp, largest bases and strides wrap the indices
      stage_register(REG_SRC_STRIDE, CSR_DATA_W'(8191));
      stage_register(REG_SRC_BASE, '1);
      stage_register(REG_SRC_REGION_W, CSR_DATA_W'(8191));
      stage_register(REG_SRC_REGION_H, CSR_DATA_W'(MAX_DIM + 1));
      stage_register(REG_DST_STRIDE, CSR_DATA_W'(8191));
      stage_register(REG_DST_BASE, '1);
      stage_register(REG_DST_REGION_W, '1);
      stage_register(REG_DST_REGION_H, CSR_DATA_W'(MAX_DIM));
      commit_registers();
      send_position(12'd4095, 12'd4095);
      send_position(12'd4095, 12'd0);
      send_position(12'd0, 12'd4095);
      send_position(12'd0, 12'd0);
      send_position(12'd2048, 12'd1);
      // Strong downscale into a tiny region
      stage_register(REG_SRC_STRIDE, CSR_DATA_W'(MAX_DIM));
      stage_register(REG_SRC_BASE, '0);
      stage_register(REG_SRC_REGION_W, CSR_DATA_W'(MAX_DIM));
      stage_register(REG_SRC_REGION_H, CSR_DATA_W'(MAX_DIM));
      stage_register(REG_DST_BASE, '0);
      stage_register(REG_DST_REGION_W, CSR_DATA_W'(3));
      stage_register(REG_DST_REGION_H, CSR_DATA_W'(7));
      commit_registers();
      send_position(12'd2, 12'd6);
      send_position(12'd1, 12'd3);
      send_position(12'd3, 12'd0);
      wait_drained();
   endtask

   task automatic test_receiver_backpressure();
      logic [POS_W-1:0] col, row;
      stage_register(REG_SRC_STRIDE, CSR_DATA_W'(320));
      stage_register(REG_SRC_BASE, CSR_DATA_W'(1000));
      stage_register(REG_SRC_REGION_W, CSR_DATA_W'(320));
      stage_register(REG_SRC_REGION_H, CSR_DATA_W'(240));
      stage_register(REG_DST_STRIDE, CSR_DATA_W'(1280));
      stage_register(REG_DST_BASE, CSR_DATA_W'(5));
      stage_register(REG_DST_REGION_W, CSR_DATA_W'(1280));
      stage_register(REG_DST_REGION_H, CSR_DATA_W'(960));
      commit_registers();
      // Long receiver hold while positions keep coming: the pipe must fill
      idle_enabled    = 1'b0;
      rsp_hold_cycles = 80;
      repeat (60) begin
         pick_position(col, row);
         send_position(col, row);
      end
      wait_drained();
   endtask

   task automatic test_sender_pause();
      logic [POS_W-1:0] col, row;
      idle_enabled = 1'b1;
      repeat (2) begin
         repeat (20) begin
            pick_position(col, row);
            send_position(col, row);
         end
         // Hold off until every result is back
         wait_drained();
      end
   endtask

   task automatic test_random_positions(input int item_total);
      int               sent, phase_len, r;
      logic [POS_W-1:0] col, row;
      sent = 0;
      while (sent < item_total) begin
         for (r = 0; r < NUM_REGS; r++) begin
            if ($urandom_range(0, 1)) begin
               if (r == int'(REG_SRC_BASE) || r == int'(REG_DST_BASE))
                  stage_register(reg_index_type'(r), pick_base_value());
               else
                  stage_register(reg_index_type'(r), pick_dim_value());
            end
         end
         commit_registers();
         idle_enabled = ($urandom_range(0, 3) != 0);
         phase_len    = $urandom_range(60, 120);
         repeat (phase_len) begin
            pick_position(col, row);
            send_position(col, row);
            sent++;
         end
      end
      wait_drained();
   endtask

   // Receiver: random stall per beat, plus a long hold when asked
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = idle_enabled ? $urandom_range(0, 5) : 0;
         if (stall > 0) begin
            if (rsp_ready) rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Compare each result beat with the oldest prediction
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_addresses.size() == 0) begin
            report_mismatch("unexpected result beat", 0, 1);
         end else begin
            want = expected_addresses.pop_front();
            if (rsp_src_byte_index !== want.src_byte_index)
               report_mismatch("src_byte_index", want.src_byte_index, rsp_src_byte_index);
            if (rsp_dst_byte_index !== want.dst_byte_index)
               report_mismatch("dst_byte_index", want.dst_byte_index, rsp_dst_byte_index);
            if (rsp_outside_region !== want.outside_region)
               report_mismatch("outside_region", want.outside_region, rsp_outside_region);
         end
      end
   end

   initial begin
      mismatch_count  = 0;
      idle_enabled    = 1'b1;
      rsp_hold_cycles = 0;
      staged_mask     = '0;
      cfg_src_stride  = RST_STRIDE;
      cfg_src_base    = RST_BASE;
      cfg_src_w       = RST_REGION_W;
      cfg_src_h       = RST_REGION_H;
      cfg_dst_stride  = RST_STRIDE;
      cfg_dst_base    = RST_BASE;
      cfg_dst_w       = RST_REGION_W;
      cfg_dst_h       = RST_REGION_H;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_dst_col <= '0;
      req_dst_row <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= REG_SRC_STRIDE;
      csr_data    <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_zero_regions();
      test_oversized_regions();
      test_receiver_backpressure();
      test_sender_pause();
      test_random_positions(930);

      // Let any stray beat surface before the verdict
      wait_drained();
      repeat (PIPE_LATENCY + 5) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/nnsa_pkg.sv
rtl/core/nnsa_csr.sv
rtl/core/nnsa_div_cell.sv
rtl/core/nnsa_out_buf.sv
rtl/core/nearest_neighbor_scale_addresser.sv
rtl/core/nnsa_checker.sv
test/tb_nearest_neighbor_scale_addresser.sv
